// ----- src/hfs_pkg.sv -----
// hfs_pkg: item types, register indexes and control structs of the HID frame sequencer.
// No dependencies.
`default_nettype none

package hfs_pkg;

    localparam int MSG_LEN_W  = 11;
    localparam int HDR_BYTES  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_OPCODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BAD_DIRECTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BAD_SEQUENCE  = 2'd2;

    localparam logic [7:0] RESET_ERROR_OPCODE       = 8'h00;
    localparam logic [7:0] RESET_CODE_BAD_DIRECTION = 8'h01;
    localparam logic [7:0] RESET_CODE_BAD_SEQUENCE  = 8'h02;

    localparam logic KIND_HOST_FRAME = 1'b0;
    localparam logic KIND_SEND       = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [6:0]           frame_length;
        logic [7:0]           opcode;
        logic [15:0]          sequence_req;
        logic [MSG_LEN_W-1:0] message_length;
    } hfs_in_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  opcode_out;
        logic [15:0] sequence_out;
        logic [5:0]  payload_length;
        logic [7:0]  error_byte;
        logic        last;
    } hfs_out_t;

    typedef struct packed {
        logic load;
        logic emit;
    } hfs_cmd_t;

    typedef struct packed {
        logic drop;
        logic last;
    } hfs_status_t;

endpackage

`default_nettype wire

// ----- src/hfs_stream_if.sv -----
// hfs_stream_if: valid/ready channel carrying one item of type T.
// Used with the item types of hfs_pkg.
`default_nettype none

interface hfs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/hfs_ctrl.sv -----
// hfs_ctrl: controller FSM; accepts items, paces result emission, owns output valid.
// Depends on hfs_pkg.
`default_nettype none

module hfs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire hfs_pkg::hfs_status_t status,
    output hfs_pkg::hfs_cmd_t        cmd
);
    import hfs_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd.load       = in_ready && in_valid;
        cmd.emit       = (state_reg == ST_EMIT) && !status.drop
                         && (!out_valid_reg || out_ready);
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.drop || (cmd.emit && status.last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- src/hfs_datapath.sv -----
// hfs_datapath: config registers, host sequence state, chunk counters, output register.
// Depends on hfs_pkg.
`default_nettype none

module hfs_datapath #(
    parameter int PAYLOAD_BYTES     = 61,
    parameter int FRAME_BYTES       = 64,
    parameter int MAX_MESSAGE_BYTES = 2047
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [hfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [hfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire hfs_pkg::hfs_in_t                    in_data,
    input  wire hfs_pkg::hfs_cmd_t                   cmd,
    output hfs_pkg::hfs_status_t                     status,
    output hfs_pkg::hfs_out_t                        out_data
);
    import hfs_pkg::*;

    localparam int REM_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int CMP_W = (REM_W > MSG_LEN_W) ? REM_W : MSG_LEN_W;

    logic [7:0]       error_opcode_reg;
    logic [7:0]       code_bad_direction_reg;
    logic [7:0]       code_bad_sequence_reg;
    logic [14:0]      last_seq_reg;
    logic             seq_seen_reg;
    hfs_in_t          item_reg;
    logic [REM_W-1:0] remaining_reg;
    logic [REM_W-1:0] remaining_next;
    logic [REM_W-1:0] chunk_idx_reg;
    hfs_out_t         out_reg;
    hfs_out_t         out_next;

    logic [CMP_W-1:0] mlen_ext;
    logic [REM_W-1:0] mlen_sat;
    logic [31:0]      clen;
    logic [31:0]      flen_sat;
    logic             chunk_fin;
    logic             bad_dir;
    logic             bad_seq;
    logic             host_ok;

    always_comb
    begin
        mlen_ext = CMP_W'(in_data.message_length);
        mlen_sat = (32'(mlen_ext) > 32'(MAX_MESSAGE_BYTES))
                   ? REM_W'(MAX_MESSAGE_BYTES) : REM_W'(mlen_ext);

        chunk_fin = (32'(remaining_reg) <= 32'(PAYLOAD_BYTES));
        clen      = chunk_fin ? 32'(remaining_reg) : 32'(PAYLOAD_BYTES);
        remaining_next = remaining_reg - REM_W'(clen);

        flen_sat = (32'(item_reg.frame_length) > 32'(FRAME_BYTES))
                   ? 32'(FRAME_BYTES) : 32'(item_reg.frame_length);

        bad_dir = item_reg.opcode[7];
        bad_seq = item_reg.sequence_req[15]
                  || (seq_seen_reg && (item_reg.sequence_req[14:0] != 15'(last_seq_reg + 15'd1)));
        host_ok = !bad_dir && !bad_seq;

        status.drop = (item_reg.kind == KIND_HOST_FRAME)
                      && (item_reg.frame_length < 7'(HDR_BYTES));
        status.last = (item_reg.kind == KIND_HOST_FRAME) || chunk_fin;

        out_next = out_reg;
        if (item_reg.kind == KIND_SEND)
        begin
            out_next.result_kind    = 1'b1;
            out_next.opcode_out     = item_reg.opcode;
            out_next.sequence_out   = {!chunk_fin, 15'(chunk_idx_reg)};
            out_next.payload_length = clen[5:0];
            out_next.error_byte     = 8'h00;
            out_next.last           = chunk_fin;
        end
        else if (host_ok)
        begin
            out_next.result_kind    = 1'b0;
            out_next.opcode_out     = item_reg.opcode;
            out_next.sequence_out   = item_reg.sequence_req;
            out_next.payload_length = 6'(flen_sat - 32'(HDR_BYTES));
            out_next.error_byte     = 8'h00;
            out_next.last           = 1'b1;
        end
        else
        begin
            out_next.result_kind    = 1'b1;
            out_next.opcode_out     = error_opcode_reg;
            out_next.sequence_out   = 16'h0000;
            out_next.payload_length = 6'd1;
            out_next.error_byte     = bad_dir ? code_bad_direction_reg : code_bad_sequence_reg;
            out_next.last           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_opcode_reg       <= RESET_ERROR_OPCODE;
            code_bad_direction_reg <= RESET_CODE_BAD_DIRECTION;
            code_bad_sequence_reg  <= RESET_CODE_BAD_SEQUENCE;
            last_seq_reg           <= '0;
            seq_seen_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ERROR_OPCODE:       error_opcode_reg       <= cfg_data;
                    CFG_CODE_BAD_DIRECTION: code_bad_direction_reg <= cfg_data;
                    CFG_CODE_BAD_SEQUENCE:  code_bad_sequence_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.emit && (item_reg.kind == KIND_HOST_FRAME) && host_ok)
            begin
                last_seq_reg <= item_reg.sequence_req[14:0];
                seq_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg      <= in_data;
            remaining_reg <= mlen_sat;
            chunk_idx_reg <= '0;
        end
        else if (cmd.emit)
        begin
            remaining_reg <= remaining_next;
            chunk_idx_reg <= chunk_idx_reg + REM_W'(1);
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ----- src/hid_frame_sequencer.sv -----
// hid_frame_sequencer: checks host frame headers and splits send requests into chunk headers.
// Depends on hfs_pkg, hfs_stream_if, hfs_ctrl, hfs_datapath.
// Host frame: no new item is taken until its result is registered or the frame is dropped as too short.
// Send request: split into chunks of up to PAYLOAD_BYTES bytes, one chunk per cycle while the output is not stalled.
// Chunk rate is set by the output register; a stalled output holds the chunk counter.
// Reset clears config to 0/1/2, the sequence baseline and all handshake state.
`default_nettype none

module hid_frame_sequencer #(
    parameter int PAYLOAD_BYTES     = 61,
    parameter int FRAME_BYTES       = 64,
    parameter int MAX_MESSAGE_BYTES = 2047
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [hfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hfs_pkg::CFG_DATA_W-1:0] cfg_data,
    hfs_stream_if.sink                          in_item,
    hfs_stream_if.source                        out_item
);
    import hfs_pkg::*;

    hfs_cmd_t    cmd;
    hfs_status_t status;
    hfs_in_t     in_data;
    hfs_out_t    out_data;

    assign in_data       = in_item.data;
    assign out_item.data = out_data;

    hfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .status    (status),
        .cmd       (cmd)
    );

    hfs_datapath #(
        .PAYLOAD_BYTES     (PAYLOAD_BYTES),
        .FRAME_BYTES       (FRAME_BYTES),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_item.valid && in_item.ready |=> !in_item.ready)
        else $error("new item taken while previous item in progress");

    a_delivery_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && (out_data.result_kind == KIND_HOST_FRAME) |-> out_data.last)
        else $error("delivered host frame not marked last");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_item.ready |-> !cmd.emit)
        else $error("result emitted while idle");

endmodule

`default_nettype wire
